// ===== hdl/iqd2_pkg.sv =====
// Shared types and constants for the IQ decimate-by-two averager with peak AGC.
`default_nettype none

package iqd2_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_W       = 5;
    localparam int PWR_W        = 32;
    localparam int PERIOD_W     = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [PWR_W-1:0]    HIGH_LEVEL_SQ_RST = 32'd42949673;
    localparam logic [PWR_W-1:0]    LOW_LEVEL_SQ_RST  = 32'd429497;
    localparam logic [PERIOD_W-1:0] AGC_PERIOD_RST    = 8'd10;
    localparam logic [GAIN_W-1:0]   GAIN_FLOOR_RST    = 5'd0;
    localparam logic [GAIN_W-1:0]   GAIN_CEILING_RST  = 5'd21;
    localparam logic [GAIN_W-1:0]   START_GAIN_RST    = 5'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AGC_ENABLE    = 3'd0,
        REG_HIGH_LEVEL_SQ = 3'd1,
        REG_LOW_LEVEL_SQ  = 3'd2,
        REG_AGC_PERIOD    = 3'd3,
        REG_GAIN_FLOOR    = 3'd4,
        REG_GAIN_CEILING  = 3'd5,
        REG_START_GAIN    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] first_i;
        logic signed [SAMPLE_WIDTH-1:0] first_q;
        logic signed [SAMPLE_WIDTH-1:0] second_i;
        logic signed [SAMPLE_WIDTH-1:0] second_q;
        logic                           frame_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_i;
        logic signed [SAMPLE_WIDTH-1:0] out_q;
        logic        [GAIN_W-1:0]       gain_now;
        logic                           gain_changed;
    } out_item_t;

    typedef struct packed {
        logic                agc_enable;
        logic [PWR_W-1:0]    high_level_sq;
        logic [PWR_W-1:0]    low_level_sq;
        logic [PERIOD_W-1:0] agc_period;
        logic [GAIN_W-1:0]   gain_floor;
        logic [GAIN_W-1:0]   gain_ceiling;
    } agc_cfg_t;

    typedef struct packed {
        logic             step;
        logic             last;
        logic [PWR_W-1:0] pwr;
        logic             pwr_gt_high;
        logic             pwr_lt_low;
    } agc_meas_t;

endpackage

`default_nettype wire

// ===== hdl/iqd2_agc.sv =====
// Peak tracking, frame phase counter and gain stepping state.
`default_nettype none

module iqd2_agc
    import iqd2_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire agc_cfg_t          cfg,
    input  wire agc_meas_t         meas,
    input  wire logic              load_gain,
    input  wire logic [GAIN_W-1:0] load_value,
    output logic      [GAIN_W-1:0] gain_now,
    output logic                   changed
);

    logic [PWR_W-1:0]    peak_reg;
    logic [PWR_W-1:0]    peak_next;
    logic [PERIOD_W-1:0] phase_reg;
    logic [PERIOD_W-1:0] phase_next;
    logic [GAIN_W-1:0]   gain_reg;
    logic [GAIN_W-1:0]   gain_next;
    logic                measuring;
    logic                above_high;
    logic                below_low;
    logic                dec_ok;
    logic                inc_ok;
    logic [PERIOD_W:0]   phase_inc;
    logic [GAIN_W:0]     gain_inc;
    logic [GAIN_W-1:0]   gain_dec;

    assign measuring  = cfg.agc_enable && (phase_reg == '0);
    assign above_high = (peak_reg > cfg.high_level_sq) || meas.pwr_gt_high;
    assign below_low  = (peak_reg < cfg.low_level_sq) && meas.pwr_lt_low;
    assign gain_dec   = gain_reg - GAIN_W'(1);
    assign gain_inc   = {1'b0, gain_reg} + (GAIN_W + 1)'(1);
    assign dec_ok     = (gain_reg != '0) && (gain_dec >= cfg.gain_floor);
    assign inc_ok     = gain_inc <= {1'b0, cfg.gain_ceiling};
    assign phase_inc  = {1'b0, phase_reg} + (PERIOD_W + 1)'(1);

    always_comb
    begin
        peak_next  = peak_reg;
        phase_next = phase_reg;
        gain_next  = gain_reg;
        changed    = 1'b0;
        if (meas.step)
        begin
            if (measuring && (meas.pwr > peak_reg))
            begin
                peak_next = meas.pwr;
            end
            if (meas.last)
            begin
                if (measuring)
                begin
                    if (above_high)
                    begin
                        if (dec_ok)
                        begin
                            gain_next = gain_dec;
                            changed   = 1'b1;
                        end
                    end
                    else if (below_low)
                    begin
                        if (inc_ok)
                        begin
                            gain_next = gain_inc[GAIN_W-1:0];
                            changed   = 1'b1;
                        end
                    end
                end
                peak_next = '0;
                if (phase_inc >= {1'b0, cfg.agc_period})
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc[PERIOD_W-1:0];
                end
            end
        end
        if (load_gain)
        begin
            gain_next = load_value;
        end
    end

    assign gain_now = gain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            phase_reg <= '0;
            gain_reg  <= START_GAIN_RST;
        end
        else
        begin
            peak_reg  <= peak_next;
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
        end
    end

    a_gain_holds_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        meas.step && !meas.last && !load_gain |=> $stable(gain_reg))
        else $error("gain moved on an item that does not end a frame");

    a_peak_cleared_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        meas.step && meas.last |=> peak_reg == '0)
        else $error("peak not cleared after frame end");

    a_no_step_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        meas.step && !cfg.agc_enable |-> !changed)
        else $error("gain stepped with AGC disabled");

endmodule

`default_nettype wire

// ===== hdl/iq_decimate_by_two_with_peak_agc.sv =====
// Top level: IQ decimate-by-two averager with peak-driven gain stepping.
//
//  port group   direction  payload      handshake
//  in_*         input      in_item_t    in_valid / in_stall
//  out_*        output     out_item_t   out_valid / out_stall
//  cfg_*        input      32-bit data  cfg_write, no back-pressure
//
// One item per clock sustained while out_stall is low; an accepted item reaches
// out_valid through five registers (input, average, square, power sum,
// AGC update and result).
// The peak, frame phase and gain state update in the last stage only, so
// back-to-back items see each other's updates in order.
// Output stall back-pressures each stage in turn; bubbles are squeezed out.
// Reset clears stage valid bits and loads configuration and AGC state defaults.
`default_nettype none

module iq_decimate_by_two_with_peak_agc
    import iqd2_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = 2 * SW;

    agc_cfg_t  cfg_reg;
    agc_meas_t meas;
    logic      load_gain;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                rdy1, rdy2, rdy3, rdy4, rdy5;

    in_item_t            s1_reg;

    logic signed [SW-1:0] avg_i_s2_reg, avg_q_s2_reg;
    logic                 last_s2_reg;
    logic signed [SW:0]   sum_i, sum_q;

    logic signed [SW-1:0] avg_i_s3_reg, avg_q_s3_reg;
    logic                 last_s3_reg;
    logic [PW-2:0]        sq_i_s3_reg, sq_q_s3_reg;
    logic signed [PW-1:0] prod_i, prod_q;

    logic signed [SW-1:0] avg_i_s4_reg, avg_q_s4_reg;
    logic                 last_s4_reg;
    logic [PWR_W-1:0]     pwr_s4_reg;
    logic                 gt_high_s4_reg, lt_low_s4_reg;
    logic [PW-1:0]        psum;
    logic [PWR_W-1:0]     pwr;

    logic [GAIN_W-1:0]    gain_now;
    logic                 changed;

    // stage readiness
    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.agc_enable    <= 1'b0;
            cfg_reg.high_level_sq <= HIGH_LEVEL_SQ_RST;
            cfg_reg.low_level_sq  <= LOW_LEVEL_SQ_RST;
            cfg_reg.agc_period    <= AGC_PERIOD_RST;
            cfg_reg.gain_floor    <= GAIN_FLOOR_RST;
            cfg_reg.gain_ceiling  <= GAIN_CEILING_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AGC_ENABLE:    cfg_reg.agc_enable    <= cfg_data[0];
                REG_HIGH_LEVEL_SQ: cfg_reg.high_level_sq <= cfg_data[PWR_W-1:0];
                REG_LOW_LEVEL_SQ:  cfg_reg.low_level_sq  <= cfg_data[PWR_W-1:0];
                REG_AGC_PERIOD:    cfg_reg.agc_period    <= cfg_data[PERIOD_W-1:0];
                REG_GAIN_FLOOR:    cfg_reg.gain_floor    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_CEILING:  cfg_reg.gain_ceiling  <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    assign load_gain = cfg_write && (cfg_index == REG_START_GAIN);

    // stage 1: hold input item
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= in_data;
        end
    end

    // stage 2: average
    assign sum_i = {s1_reg.first_i[SW-1], s1_reg.first_i}
                 + {s1_reg.second_i[SW-1], s1_reg.second_i};
    assign sum_q = {s1_reg.first_q[SW-1], s1_reg.first_q}
                 + {s1_reg.second_q[SW-1], s1_reg.second_q};

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            avg_i_s2_reg <= sum_i[SW:1];
            avg_q_s2_reg <= sum_q[SW:1];
            last_s2_reg  <= s1_reg.frame_last;
        end
    end

    // stage 3: squares
    assign prod_i = avg_i_s2_reg * avg_i_s2_reg;
    assign prod_q = avg_q_s2_reg * avg_q_s2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            avg_i_s3_reg <= avg_i_s2_reg;
            avg_q_s3_reg <= avg_q_s2_reg;
            last_s3_reg  <= last_s2_reg;
            sq_i_s3_reg  <= prod_i[PW-2:0];
            sq_q_s3_reg  <= prod_q[PW-2:0];
        end
    end

    // stage 4: power in Q2.30 and threshold compares
    assign psum = {1'b0, sq_i_s3_reg} + {1'b0, sq_q_s3_reg};

    generate
        if (SW >= 16)
        begin : g_scale_down
            assign pwr = psum[PW-1:PW-PWR_W];
        end
        else
        begin : g_scale_up
            assign pwr = {psum, {(PWR_W - PW){1'b0}}};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            avg_i_s4_reg   <= avg_i_s3_reg;
            avg_q_s4_reg   <= avg_q_s3_reg;
            last_s4_reg    <= last_s3_reg;
            pwr_s4_reg     <= pwr;
            gt_high_s4_reg <= pwr > cfg_reg.high_level_sq;
            lt_low_s4_reg  <= pwr < cfg_reg.low_level_sq;
        end
    end

    // stage 5: AGC update and result
    assign meas.step        = rdy5 && v4_reg;
    assign meas.last        = last_s4_reg;
    assign meas.pwr         = pwr_s4_reg;
    assign meas.pwr_gt_high = gt_high_s4_reg;
    assign meas.pwr_lt_low  = lt_low_s4_reg;

    iqd2_agc u_agc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .meas       (meas),
        .load_gain  (load_gain),
        .load_value (cfg_data[GAIN_W-1:0]),
        .gain_now   (gain_now),
        .changed    (changed)
    );

    always_ff @(posedge clk)
    begin
        if (meas.step)
        begin
            out_data.out_i        <= avg_i_s4_reg;
            out_data.out_q        <= avg_q_s4_reg;
            out_data.gain_now     <= gain_now;
            out_data.gain_changed <= changed;
        end
    end

    a_empty_front_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !in_stall)
        else $error("input stalled with an empty first stage");

    a_result_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && out_valid && !out_stall |=> out_valid)
        else $error("result lost between power stage and output");

    a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        else $error("input stalled while a bubble remains");

endmodule

`default_nettype wire

// ===== test/tb_iq_decimate_by_two_with_peak_agc.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the IQ decimate-by-two averager with peak-driven gain stepping.

module tb_iq_decimate_by_two_with_peak_agc;
    import iqd2_pkg::*;

    class decimated_sample_board;
        agc_cfg_t            cfg;
        logic [GAIN_W-1:0]   start_gain;
        logic [PWR_W-1:0]    peak_sq;
        logic [PERIOD_W-1:0] phase;
        logic [GAIN_W-1:0]   gain;
        out_item_t           expected_samples[$];
        int                  mismatches;
        int                  samples_checked;
        int                  gain_steps;

        function new();
            cfg.agc_enable    = 1'b0;
            cfg.high_level_sq = HIGH_LEVEL_SQ_RST;
            cfg.low_level_sq  = LOW_LEVEL_SQ_RST;
            cfg.agc_period    = AGC_PERIOD_RST;
            cfg.gain_floor    = GAIN_FLOOR_RST;
            cfg.gain_ceiling  = GAIN_CEILING_RST;
            start_gain        = START_GAIN_RST;
            peak_sq           = '0;
            phase             = '0;
            gain              = START_GAIN_RST;
            mismatches        = 0;
            samples_checked   = 0;
            gain_steps        = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_AGC_ENABLE:    cfg.agc_enable = value[0];
                REG_HIGH_LEVEL_SQ: cfg.high_level_sq = value[PWR_W-1:0];
                REG_LOW_LEVEL_SQ:  cfg.low_level_sq = value[PWR_W-1:0];
                REG_AGC_PERIOD:    cfg.agc_period = value[PERIOD_W-1:0];
                REG_GAIN_FLOOR:    cfg.gain_floor = value[GAIN_W-1:0];
                REG_GAIN_CEILING:  cfg.gain_ceiling = value[GAIN_W-1:0];
                REG_START_GAIN:
                begin
                    start_gain = value[GAIN_W-1:0];
                    gain       = start_gain;
                end
                default: ;
            endcase
        endfunction

        function void accept_pair(in_item_t pair);
            int               si;
            int               sq;
            longint           pw;
            logic [PWR_W-1:0] power;
            logic             measuring;
            logic             changed;
            int               next_phase;
            out_item_t        res;
            si = (int'($signed(pair.first_i)) + int'($signed(pair.second_i))) >>> 1;
            sq = (int'($signed(pair.first_q)) + int'($signed(pair.second_q))) >>> 1;
            pw = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
            power = pw[PWR_W-1:0];
            measuring = cfg.agc_enable && (phase == '0);
            changed = 1'b0;
            if (measuring && power > peak_sq)
                peak_sq = power;
            if (pair.frame_last)
            begin
                if (measuring)
                begin
                    if (peak_sq > cfg.high_level_sq)
                    begin
                        if (int'(gain) >= 1 && int'(gain) - 1 >= int'(cfg.gain_floor))
                        begin
                            gain    = gain - 1'b1;
                            changed = 1'b1;
                        end
                    end
                    else if (peak_sq < cfg.low_level_sq)
                    begin
                        if (int'(gain) + 1 <= int'(cfg.gain_ceiling))
                        begin
                            gain    = gain + 1'b1;
                            changed = 1'b1;
                        end
                    end
                end
                peak_sq = '0;
                next_phase = int'(phase) + 1;
                phase = (next_phase >= int'(cfg.agc_period)) ? '0 : PERIOD_W'(next_phase);
            end
            res.out_i        = si[SAMPLE_WIDTH-1:0];
            res.out_q        = sq[SAMPLE_WIDTH-1:0];
            res.gain_now     = gain;
            res.gain_changed = changed;
            expected_samples.push_back(res);
        endfunction

        function void check_sample(out_item_t got);
            out_item_t want;
            if (expected_samples.size() == 0)
            begin
                $error("out_i: expected none, actual %0d (unexpected result)", got.out_i);
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.out_i !== want.out_i)
            begin
                $error("out_i: expected %0d, actual %0d", want.out_i, got.out_i);
                mismatches++;
            end
            if (got.out_q !== want.out_q)
            begin
                $error("out_q: expected %0d, actual %0d", want.out_q, got.out_q);
                mismatches++;
            end
            if (got.gain_now !== want.gain_now)
            begin
                $error("gain_now: expected %0d, actual %0d", want.gain_now, got.gain_now);
                mismatches++;
            end
            if (got.gain_changed !== want.gain_changed)
            begin
                $error("gain_changed: expected %0d, actual %0d",
                       want.gain_changed, got.gain_changed);
                mismatches++;
            end
            samples_checked++;
            if (want.gain_changed)
                gain_steps++;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    decimated_sample_board board = new();

    int burst_left = 0;
    int items_sent = 0;
    int settings_applied = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;

    iq_decimate_by_two_with_peak_agc i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 300);
        end
        stall_mode_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_mode_left % 37) < 24);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_sample(out_data);
    end

    function automatic in_item_t make_pair(input int a, input int b, input int c,
                                           input int d, input logic last);
        in_item_t p;
        p.first_i    = SAMPLE_WIDTH'(a);
        p.first_q    = SAMPLE_WIDTH'(b);
        p.second_i   = SAMPLE_WIDTH'(c);
        p.second_q   = SAMPLE_WIDTH'(d);
        p.frame_last = last;
        return p;
    endfunction

    function automatic int rand_sample(input int level);
        case (level)
            0:       return int'($urandom_range(0, 65535));
            1:       return int'($urandom_range(0, 400)) - 200;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(0, 16000)) - 8000;
        endcase
    endfunction

    function automatic in_item_t random_pair(input int level, input logic last);
        return make_pair(rand_sample(level), rand_sample(level), rand_sample(level),
                         rand_sample(level), last);
    endfunction

    function automatic agc_cfg_t make_setting(input logic en, input logic [PWR_W-1:0] hi,
                                              input logic [PWR_W-1:0] lo, input int period,
                                              input int floor_g, input int ceil_g);
        agc_cfg_t s;
        s.agc_enable    = en;
        s.high_level_sq = hi;
        s.low_level_sq  = lo;
        s.agc_period    = PERIOD_W'(period);
        s.gain_floor    = GAIN_W'(floor_g);
        s.gain_ceiling  = GAIN_W'(ceil_g);
        return s;
    endfunction

    function automatic agc_cfg_t random_setting(input int idx);
        logic [PWR_W-1:0] hi;
        logic [PWR_W-1:0] lo;
        int               period;
        int               floor_g;
        case ($urandom_range(0, 3))
            0:
            begin
                hi = HIGH_LEVEL_SQ_RST;
                lo = LOW_LEVEL_SQ_RST;
            end
            1:
            begin
                hi = 32'h8000_0000;
                lo = '0;
            end
            2:
            begin
                hi = '0;
                lo = 32'h8000_0000;
            end
            default:
            begin
                lo = $urandom_range(0, 32'h0100_0000);
                hi = $urandom_range(lo, 32'h8000_0000);
            end
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: period = $urandom_range(1, 4);
            3:       period = 255;
            4:       period = $urandom_range(1, 255);
            default: period = 1;
        endcase
        if (idx == 0)
            period = 255;
        floor_g = $urandom_range(0, 21);
        return make_setting($urandom_range(0, 5) != 0, hi, lo, period, floor_g,
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 21)
                                                        : $urandom_range(floor_g, 21));
    endfunction

    task automatic send_pair(input in_item_t pair);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= pair;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.accept_pair(pair);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // hold off until every expected sample has come, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_samples.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.write_reg(idx, value);
        @(negedge clk);
    endtask

    // a negative start gain leaves the current gain alone
    task automatic apply_setting(input agc_cfg_t s, input int start);
        drain();
        set_reg(REG_AGC_ENABLE, CFG_DATA_W'(s.agc_enable));
        set_reg(REG_HIGH_LEVEL_SQ, CFG_DATA_W'(s.high_level_sq));
        set_reg(REG_LOW_LEVEL_SQ, CFG_DATA_W'(s.low_level_sq));
        set_reg(REG_AGC_PERIOD, CFG_DATA_W'(s.agc_period));
        set_reg(REG_GAIN_FLOOR, CFG_DATA_W'(s.gain_floor));
        set_reg(REG_GAIN_CEILING, CFG_DATA_W'(s.gain_ceiling));
        if (start >= 0)
            set_reg(REG_START_GAIN, CFG_DATA_W'(start));
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    task automatic directed_pairs();
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 1, 0, 21), 10);
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1'b1));
        send_pair(make_pair(32767, 32767, 32767, 32767, 1'b1));
        send_pair(make_pair(32767, -32768, -32768, 32767, 1'b1));
        send_pair(make_pair(1, -1, 0, 0, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        // peak equal to either threshold, zero period
        apply_setting(make_setting(1'b1, 32'h8000_0000, '0, 0, 0, 21), 20);
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 1, 9, 9), 9);
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 1, 0, 21), 0);
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 1, 0, 21), 21);
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        // gain above the ceiling
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 1, 2, 5), 15);
        send_pair(make_pair(32767, -32768, 32767, -32768, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        send_pair(make_pair(32767, -32768, 32767, -32768, 1'b1));
        apply_setting(make_setting(1'b0, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 3, 0, 21), -1);
        send_pair(make_pair(-32768, -32768, -32768, -32768, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        // shrink the period while the phase sits above it
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 10, 0, 21), -1);
        repeat (5) send_pair(make_pair(0, 0, 0, 0, 1'b1));
        apply_setting(make_setting(1'b1, HIGH_LEVEL_SQ_RST, LOW_LEVEL_SQ_RST, 3, 0, 21), -1);
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int len;
        int level;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_pair(random_pair($urandom_range(0, 3), $urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len   = $urandom_range(1, 8);
                level = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    send_pair(random_pair(level, k == len - 1));
                sent += len;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_pairs();
        for (int p = 0; p < 7; p++)
        begin
            apply_setting(random_setting(p),
                          ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 21));
            random_traffic(200);
        end
        drain();
        $display("Sent %0d sample pairs under %0d register settings.",
                 items_sent, settings_applied);
        $display("Checked %0d averaged samples, %0d of them with a gain step.",
                 board.samples_checked, board.gain_steps);
        if (board.mismatches == 0 && board.expected_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
